/* hdl/cdad_pkg.sv */
// Shared types, constants and the control store of the date adder.
// Holds calendar tables and the microcode program; no dependencies.
package cdad_pkg;

  localparam int DATE_W = 27;
  localparam int OUT_W  = 32;
  localparam int PC_W   = 5;
  localparam int Q_W    = 8;
  localparam int K_W    = 3;
  localparam int CENT_W = 8;
  localparam int YY_W   = 7;
  localparam int MON_W  = 4;
  localparam int DAY_W  = 5;
  localparam int YEAR_W = 14;
  localparam int CUM_W  = 9;

  localparam logic [DATE_W-1:0] DIV_MEG  = 27'd1000000;
  localparam logic [DATE_W-1:0] DIV_TENK = 27'd10000;
  localparam logic [DATE_W-1:0] DIV_HUND = 27'd100;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_DIV_MEG, OP_DIV_TENK, OP_DIV_HUND, OP_CENT, OP_YY,
    OP_MD, OP_PROV, OP_DOY, OP_FWD, OP_DEC, OP_ADDY, OP_MINIT, OP_MINC,
    OP_MDAY, OP_SAME, OP_SETERR, OP_FMT
  } op_e;

  typedef enum logic [3:0] {
    C_NEVER, C_ALWAYS, C_NOIN, C_KNZ, C_BAD, C_INMON, C_NEG, C_FITS,
    C_YLAST, C_POS, C_YZERO, C_MDONE, C_OFULL
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [PC_W-1:0]  target;
  } uword_t;

  typedef struct packed {
    logic noin;
    logic knz;
    logic bad;
    logic inmon;
    logic neg;
    logic fits;
    logic ylast;
    logic pos;
    logic yzero;
    logic mdone;
    logic ofull;
  } flags_t;

  function automatic uword_t mk(op_e op, cond_e cond, logic [PC_W-1:0] target);
    uword_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // Program: split yyyymmdd, validate, shift inside month or walk years,
  // then scan months and format.
  function automatic uword_t ucode(logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      5'd0:    w = mk(OP_LOAD,     C_NOIN,   5'd0);
      5'd1:    w = mk(OP_DIV_MEG,  C_KNZ,    5'd1);
      5'd2:    w = mk(OP_CENT,     C_NEVER,  5'd0);
      5'd3:    w = mk(OP_DIV_TENK, C_KNZ,    5'd3);
      5'd4:    w = mk(OP_YY,       C_NEVER,  5'd0);
      5'd5:    w = mk(OP_DIV_HUND, C_KNZ,    5'd5);
      5'd6:    w = mk(OP_MD,       C_NEVER,  5'd0);
      5'd7:    w = mk(OP_PROV,     C_BAD,    5'd24);
      5'd8:    w = mk(OP_NOP,      C_INMON,  5'd23);
      5'd9:    w = mk(OP_DOY,      C_NEVER,  5'd0);
      5'd10:   w = mk(OP_NOP,      C_NEG,    5'd14);
      5'd11:   w = mk(OP_NOP,      C_FITS,   5'd17);
      5'd12:   w = mk(OP_FWD,      C_YLAST,  5'd24);
      5'd13:   w = mk(OP_NOP,      C_ALWAYS, 5'd11);
      5'd14:   w = mk(OP_NOP,      C_POS,    5'd17);
      5'd15:   w = mk(OP_DEC,      C_YZERO,  5'd24);
      5'd16:   w = mk(OP_ADDY,     C_ALWAYS, 5'd14);
      5'd17:   w = mk(OP_MINIT,    C_NEVER,  5'd0);
      5'd18:   w = mk(OP_NOP,      C_MDONE,  5'd20);
      5'd19:   w = mk(OP_MINC,     C_ALWAYS, 5'd18);
      5'd20:   w = mk(OP_MDAY,     C_NEVER,  5'd0);
      5'd21:   w = mk(OP_FMT,      C_OFULL,  5'd21);
      5'd22:   w = mk(OP_NOP,      C_ALWAYS, 5'd0);
      5'd23:   w = mk(OP_SAME,     C_ALWAYS, 5'd21);
      5'd24:   w = mk(OP_SETERR,   C_ALWAYS, 5'd21);
      default: w = mk(OP_NOP,      C_ALWAYS, 5'd0);
    endcase
    return w;
  endfunction

  // Days before month index (0 = January).
  function automatic logic [CUM_W-1:0] cum_days(logic [MON_W-1:0] idx, logic leap);
    logic [CUM_W-1:0] c;
    case (idx)
      4'd0:    c = 9'd0;
      4'd1:    c = 9'd31;
      4'd2:    c = 9'd59;
      4'd3:    c = 9'd90;
      4'd4:    c = 9'd120;
      4'd5:    c = 9'd151;
      4'd6:    c = 9'd181;
      4'd7:    c = 9'd212;
      4'd8:    c = 9'd243;
      4'd9:    c = 9'd273;
      4'd10:   c = 9'd304;
      4'd11:   c = 9'd334;
      default: c = 9'd0;
    endcase
    if (leap && idx >= 4'd2 && idx <= 4'd11) begin
      c = c + 9'd1;
    end
    return c;
  endfunction

  // Month length, month numbered from 1.
  function automatic logic [DAY_W-1:0] month_days(logic [MON_W-1:0] m, logic leap);
    logic [DAY_W-1:0] d;
    case (m)
      4'd2:    d = leap ? 5'd29 : 5'd28;
      4'd4:    d = 5'd30;
      4'd6:    d = 5'd30;
      4'd9:    d = 5'd30;
      4'd11:   d = 5'd30;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

/* hdl/cdad_seq.sv */
// Microcode sequencer: step counter, control store lookup, jump select.
// Depends on cdad_pkg for the program and the word and flag types.
module cdad_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cdad_pkg::flags_t flags_i,
  output cdad_pkg::uword_t uword_o
);
  import cdad_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  uword_t          uw;
  logic            take;

  assign uw      = ucode(pc_q);
  assign uword_o = uw;

  always_comb begin
    case (uw.cond)
      C_NEVER:  take = 1'b0;
      C_ALWAYS: take = 1'b1;
      C_NOIN:   take = flags_i.noin;
      C_KNZ:    take = flags_i.knz;
      C_BAD:    take = flags_i.bad;
      C_INMON:  take = flags_i.inmon;
      C_NEG:    take = flags_i.neg;
      C_FITS:   take = flags_i.fits;
      C_YLAST:  take = flags_i.ylast;
      C_POS:    take = flags_i.pos;
      C_YZERO:  take = flags_i.yzero;
      C_MDONE:  take = flags_i.mdone;
      C_OFULL:  take = flags_i.ofull;
      default:  take = 1'b0;
    endcase
    pc_d = take ? uw.target : pc_q + PC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

/* hdl/cdad_datapath.sv */
// Datapath driven by the control word: decimal split, day-of-year math,
// year walk, month scan and the output word register. Uses cdad_pkg.
module cdad_datapath #(
  parameter int OFFSET_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cdad_pkg::uword_t              uword_i,
  input  logic                          in_valid_i,
  input  logic [cdad_pkg::DATE_W-1:0]   start_date_i,
  input  logic signed [OFFSET_BITS-1:0] day_offset_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [cdad_pkg::DATE_W-1:0]   end_date_o,
  output logic                          date_error_o,
  output cdad_pkg::flags_t              flags_o
);
  import cdad_pkg::*;

  localparam int DoyW = OFFSET_BITS + 2;

  logic [DATE_W-1:0]            rem_q, rem_d;
  logic [Q_W-1:0]               q_q, q_d;
  logic [K_W-1:0]               k_q, k_d;
  logic [CENT_W-1:0]            cent_q, cent_d;
  logic [YY_W-1:0]              yy_q, yy_d;
  logic [YY_W-1:0]              mm_q, mm_d;
  logic [YY_W-1:0]              dd_q, dd_d;
  logic signed [OFFSET_BITS-1:0] off_q, off_d;
  logic signed [DoyW-1:0]       doy_q, doy_d;
  logic [MON_W-1:0]             mon_q, mon_d;
  logic [DAY_W-1:0]             day_q, day_d;
  logic [YEAR_W-1:0]            year_q, year_d;
  logic                         err_q, err_d;
  logic                         ovalid_q, ovalid_d;
  logic [DATE_W-1:0]            odate_q, odate_d;
  logic                         oerr_q, oerr_d;

  logic [DATE_W-1:0]      dvs;
  logic                   leap;
  logic [CUM_W-1:0]       ylen;
  logic signed [DoyW-1:0] ylen_x, mlen_x, cum_x, off_x, dd_x, cum_mm_x;
  logic [CUM_W-1:0]       mday_diff;
  logic [YEAR_W-1:0]      year_now;
  logic                   ofull, doy_pos;

  assign leap     = (yy_q == '0) ? (cent_q[1:0] == 2'd0) : (yy_q[1:0] == 2'd0);
  assign ylen     = leap ? 9'd366 : 9'd365;
  assign ylen_x   = {{(DoyW-CUM_W){1'b0}}, ylen};
  assign mlen_x   = {{(DoyW-DAY_W){1'b0}}, month_days(mm_q[MON_W-1:0], leap)};
  assign cum_x    = {{(DoyW-CUM_W){1'b0}}, cum_days(mon_q, leap)};
  assign cum_mm_x = {{(DoyW-CUM_W){1'b0}}, cum_days(mm_q[MON_W-1:0] - MON_W'(1), leap)};
  assign off_x    = {{2{off_q[OFFSET_BITS-1]}}, off_q};
  assign dd_x     = {{(DoyW-YY_W){1'b0}}, dd_q};
  assign mday_diff = doy_q[CUM_W-1:0] - cum_days(mon_q - MON_W'(1), leap);
  assign year_now = YEAR_W'(cent_q) * YEAR_W'(100) + YEAR_W'(yy_q);
  assign ofull    = ovalid_q && !out_ready_i;
  assign doy_pos  = !doy_q[DoyW-1] && (doy_q != '0);

  always_comb begin
    case (uword_i.op)
      OP_DIV_MEG:  dvs = DIV_MEG << k_q;
      OP_DIV_TENK: dvs = DIV_TENK << k_q;
      default:     dvs = DIV_HUND << k_q;
    endcase
  end

  always_comb begin
    flags_o.noin  = !in_valid_i;
    flags_o.knz   = (k_q != '0);
    flags_o.bad   = (cent_q > 8'd99) || (mm_q == '0) || (mm_q > 7'd12) ||
                    (dd_q == '0) || (dd_x > mlen_x);
    flags_o.inmon = doy_pos && (doy_q <= mlen_x);
    flags_o.neg   = off_q[OFFSET_BITS-1];
    flags_o.fits  = (doy_q <= ylen_x);
    flags_o.ylast = (cent_q == 8'd99) && (yy_q == 7'd99);
    flags_o.pos   = doy_pos;
    flags_o.yzero = (cent_q == '0) && (yy_q == '0);
    flags_o.mdone = (mon_q == 4'd12) || (doy_q <= cum_x);
    flags_o.ofull = ofull;
  end

  always_comb begin
    rem_d    = rem_q;
    q_d      = q_q;
    k_d      = k_q;
    cent_d   = cent_q;
    yy_d     = yy_q;
    mm_d     = mm_q;
    dd_d     = dd_q;
    off_d    = off_q;
    doy_d    = doy_q;
    mon_d    = mon_q;
    day_d    = day_q;
    year_d   = year_q;
    err_d    = err_q;
    ovalid_d = ovalid_q && !out_ready_i;
    odate_d  = odate_q;
    oerr_d   = oerr_q;
    case (uword_i.op)
      OP_LOAD: begin
        if (in_valid_i) begin
          rem_d = start_date_i;
          off_d = day_offset_i;
          q_d   = '0;
          k_d   = '1;
          err_d = 1'b0;
        end
      end
      OP_DIV_MEG, OP_DIV_TENK, OP_DIV_HUND: begin
        if (rem_q >= dvs) begin
          rem_d = rem_q - dvs;
          q_d   = {q_q[Q_W-2:0], 1'b1};
        end else begin
          q_d   = {q_q[Q_W-2:0], 1'b0};
        end
        k_d = k_q - K_W'(1);
      end
      OP_CENT: begin
        cent_d = q_q;
        k_d    = '1;
      end
      OP_YY: begin
        yy_d = q_q[YY_W-1:0];
        k_d  = '1;
      end
      OP_MD: begin
        mm_d = q_q[YY_W-1:0];
        dd_d = rem_q[YY_W-1:0];
      end
      OP_PROV: doy_d = dd_x + off_x;
      OP_DOY:  doy_d = doy_q + cum_mm_x;
      OP_FWD: begin
        doy_d = doy_q - ylen_x;
        if (yy_q == 7'd99) begin
          yy_d   = '0;
          cent_d = cent_q + CENT_W'(1);
        end else begin
          yy_d   = yy_q + YY_W'(1);
        end
      end
      OP_DEC: begin
        if (yy_q == '0) begin
          yy_d   = 7'd99;
          cent_d = cent_q - CENT_W'(1);
        end else begin
          yy_d   = yy_q - YY_W'(1);
        end
      end
      OP_ADDY:  doy_d = doy_q + ylen_x;
      OP_MINIT: mon_d = 4'd1;
      OP_MINC:  mon_d = mon_q + MON_W'(1);
      OP_MDAY: begin
        day_d  = mday_diff[DAY_W-1:0];
        year_d = year_now;
      end
      OP_SAME: begin
        mon_d  = mm_q[MON_W-1:0];
        day_d  = doy_q[DAY_W-1:0];
        year_d = year_now;
      end
      OP_SETERR: err_d = 1'b1;
      OP_FMT: begin
        if (!ofull) begin
          ovalid_d = 1'b1;
          oerr_d   = err_q;
          odate_d  = err_q ? '0 :
                     DATE_W'(year_q) * DATE_W'(10000) + DATE_W'(mon_q) * DATE_W'(100) +
                     DATE_W'(day_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      err_q    <= 1'b0;
      k_q      <= '0;
    end else begin
      ovalid_q <= ovalid_d;
      err_q    <= err_d;
      k_q      <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    q_q     <= q_d;
    cent_q  <= cent_d;
    yy_q    <= yy_d;
    mm_q    <= mm_d;
    dd_q    <= dd_d;
    off_q   <= off_d;
    doy_q   <= doy_d;
    mon_q   <= mon_d;
    day_q   <= day_d;
    year_q  <= year_d;
    odate_q <= odate_d;
    oerr_q  <= oerr_d;
  end

  assign out_valid_o  = ovalid_q;
  assign end_date_o   = odate_q;
  assign date_error_o = oerr_q;

endmodule

/* hdl/calendar_date_add_days_top.sv */
// Gregorian date plus signed day offset, top level.
// Uses cdad_pkg, cdad_seq and cdad_datapath.
//
// Takes one word at a time and returns one result word for it. The start date is split
// by shift-subtract, then checked; if the shifted day stays in its month the result is
// formatted directly. Otherwise the microcoded sequencer walks whole years and scans
// months; for a large offset the year walk loop dominates the run time. A new input
// word is taken once the sequencer is back at its first step, while the previous result
// may still sit in the output register. date_error flags an invalid start date or a
// result year outside 0..9999, with end_date then 0.
module calendar_date_add_days_top #(
  parameter int OFFSET_BITS = 16,
  localparam int InW = ((cdad_pkg::DATE_W + OFFSET_BITS + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [InW-1:0]               s_axis_tdata_i,  // start_date, day_offset
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [cdad_pkg::OUT_W-1:0]   m_axis_tdata_o,  // end_date
  output logic                         m_axis_tuser_o   // date_error
);
  import cdad_pkg::*;

  uword_t            uw;
  flags_t            flags;
  logic [DATE_W-1:0] end_date;

  cdad_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .uword_o (uw)
  );

  cdad_datapath #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .uword_i      (uw),
    .in_valid_i   (s_axis_tvalid_i),
    .start_date_i (s_axis_tdata_i[DATE_W-1:0]),
    .day_offset_i (s_axis_tdata_i[DATE_W +: OFFSET_BITS]),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .end_date_o   (end_date),
    .date_error_o (m_axis_tuser_o),
    .flags_o      (flags)
  );

  assign s_axis_tready_o = (uw.op == OP_LOAD);
  assign m_axis_tdata_o  = {{(OUT_W-DATE_W){1'b0}}, end_date};

endmodule

/* hdl/cdad_checker.sv */
// Port-level checker for the date adder, bound to the top level.
// Depends on cdad_pkg and calendar_date_add_days_top.
module cdad_checker #(
  parameter int OFFSET_BITS = 16,
  localparam int InW = ((cdad_pkg::DATE_W + OFFSET_BITS + 7) / 8) * 8
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid_i,
  input logic                       s_axis_tready_o,
  input logic [InW-1:0]             s_axis_tdata_i,   // start_date, day_offset
  input logic                       m_axis_tvalid_o,
  input logic                       m_axis_tready_i,
  input logic [cdad_pkg::OUT_W-1:0] m_axis_tdata_o,   // end_date
  input logic                       m_axis_tuser_o    // date_error
);
  import cdad_pkg::*;

  logic [1:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_no_orphan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> pend_q != 2'd0)
    else $error("result word without a pending input word");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> pend_q != 2'd2)
    else $error("input word taken with two words already pending");

  a_error_zero_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("error result carries a nonzero date");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result word dropped or changed");

endmodule

bind calendar_date_add_days_top cdad_checker #(
  .OFFSET_BITS (OFFSET_BITS)
) u_cdad_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

/* verif/date_add_checker.sv */
// Checker for the date adder: watches both stream channels, predicts each result word
// from the accepted input word and compares end_date and date_error in order.
// Depends on cdad_pkg for the date field width.
module date_add_checker #(
  parameter int OFFSET_BITS = 16,
  parameter int InW = ((cdad_pkg::DATE_W + OFFSET_BITS + 7) / 8) * 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_tvalid_i,
  input  logic                       s_tready_i,
  input  logic [InW-1:0]             s_tdata_i,   // start_date, day_offset
  input  logic                       m_tvalid_i,
  input  logic                       m_tready_i,
  input  logic [cdad_pkg::OUT_W-1:0] m_tdata_i,   // end_date
  input  logic                       m_tuser_i,   // date_error
  output int                         fail_count_o,
  output int                         outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = cdad_pkg::DATE_W;

  typedef struct packed {
    logic [DW-1:0] end_date;
    logic          date_error;
  } date_result_t;

  date_result_t pending_dates[$];
  int           fails = 0;

  function automatic bit is_leap(int y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int year_days(int y);
    return is_leap(y) ? 366 : 365;
  endfunction

  function automatic int month_length(int m, int y);
    case (m)
      2:          return is_leap(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:    return 31;
    endcase
  endfunction

  // Days in the year before the first of month m (1..12).
  function automatic int days_before(int m, bit lp);
    int c;
    case (m)
      2:       c = 31;
      3:       c = 59;
      4:       c = 90;
      5:       c = 120;
      6:       c = 151;
      7:       c = 181;
      8:       c = 212;
      9:       c = 243;
      10:      c = 273;
      11:      c = 304;
      12:      c = 334;
      default: c = 0;
    endcase
    if (lp && m > 2) c = c + 1;
    return c;
  endfunction

  function automatic date_result_t shift_date(logic [DW-1:0] start,
                                              logic [OFFSET_BITS-1:0] raw);
    date_result_t                   r;
    logic signed [OFFSET_BITS-1:0]  sraw;
    int                             off, full, yy, mm, dd, prov, yr, doy, m;
    sraw = raw;
    off  = sraw;
    full = int'(start);
    yy   = full / 10000;
    mm   = (full / 100) % 100;
    dd   = full % 100;
    r.end_date   = '0;
    r.date_error = 1'b1;
    if (yy > 9999 || mm < 1 || mm > 12 || dd < 1 || dd > month_length(mm, yy)) return r;

    prov = dd + off;
    if (prov >= 1 && prov <= month_length(mm, yy)) begin
      r.end_date   = DW'(yy * 10000 + mm * 100 + prov);
      r.date_error = 1'b0;
      return r;
    end

    yr  = yy;
    doy = dd + days_before(mm, is_leap(yy)) + off;
    if (off >= 0) begin
      while (doy > year_days(yr)) begin
        doy = doy - year_days(yr);
        yr  = yr + 1;
        if (yr > 9999) return r;
      end
    end else begin
      while (doy < 1) begin
        yr = yr - 1;
        if (yr < 0) return r;
        doy = doy + year_days(yr);
      end
    end

    m = 1;
    while (m < 12 && doy > days_before(m + 1, is_leap(yr))) m = m + 1;
    r.end_date   = DW'(yr * 10000 + m * 100 + doy - days_before(m, is_leap(yr)));
    r.date_error = 1'b0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    date_result_t want;
    date_result_t got;
    if (!rst_ni) begin
      pending_dates.delete();
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.end_date   = m_tdata_i[DW-1:0];
        got.date_error = m_tuser_i;
        if (pending_dates.size() == 0) begin
          $error("result word with no pending date: end_date %0d date_error %0b",
                 got.end_date, got.date_error);
          fails++;
        end else begin
          want = pending_dates.pop_front();
          if (got.end_date !== want.end_date) begin
            $error("end_date: expected %0d, got %0d", want.end_date, got.end_date);
            fails++;
          end
          if (got.date_error !== want.date_error) begin
            $error("date_error: expected %0b, got %0b", want.date_error, got.date_error);
            fails++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        pending_dates.push_back(shift_date(s_tdata_i[DW-1:0], s_tdata_i[DW +: OFFSET_BITS]));
      end
      outstanding_o <= pending_dates.size();
      fail_count_o  <= fails;
    end
  end

endmodule

/* verif/tb.sv */
// Testbench top for the date adder: clock, reset, directed and random date words,
// bursty input and stalling output. Depends on cdad_pkg, calendar_date_add_days_top
// and date_add_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OFFSET_BITS = 16;
  localparam int DW          = cdad_pkg::DATE_W;
  localparam int InW         = ((DW + OFFSET_BITS + 7) / 8) * 8;
  localparam int RAND_WORDS  = 1050;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int DRAIN       = 400;

  logic                       clk;
  logic                       rst_n    = 1'b0;
  logic                       s_tvalid = 1'b0;
  logic [InW-1:0]             s_tdata  = '0;
  logic                       s_tready;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [cdad_pkg::OUT_W-1:0] m_tdata;
  logic                       m_tuser;
  int                         fail_count;
  int                         outstanding;
  int                         burst_left = 0;
  int                         cycle_count = 0;

  calendar_date_add_days_top #(.OFFSET_BITS(OFFSET_BITS)) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  date_add_checker #(.OFFSET_BITS(OFFSET_BITS), .InW(InW)) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .m_tuser_i     (m_tuser),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [InW-1:0] pack_word(int date, int off);
    logic [InW-1:0] w;
    w = '0;
    w[DW-1:0] = date[DW-1:0];
    w[DW +: OFFSET_BITS] = off[OFFSET_BITS-1:0];
    return w;
  endfunction

  function automatic int month_end(int m, int y);
    bit lp;
    lp = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    case (m)
      2:           return lp ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic int good_date(int y);
    int m, d;
    m = $urandom_range(1, 12);
    case ($urandom_range(0, 3))
      0:       d = month_end(m, y);
      1:       d = 1;
      default: d = $urandom_range(1, month_end(m, y));
    endcase
    return y * 10000 + m * 100 + d;
  endfunction

  function automatic int rand_offset();
    logic signed [OFFSET_BITS-1:0] r;
    r = OFFSET_BITS'($urandom);
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 80) - 40;
      1:       return $urandom_range(0, 2000) - 1000;
      default: return r;
    endcase
  endfunction

  function automatic logic [InW-1:0] rand_word();
    int             y, m, d, off, pick;
    logic [DW-1:0]  rd;
    pick = $urandom_range(0, 99);
    off  = rand_offset();
    if (pick < 60) begin
      return pack_word(good_date($urandom_range(0, 9999)), off);
    end else if (pick < 70) begin
      if ($urandom_range(0, 1)) begin
        y   = $urandom_range(0, 3);
        off = -$urandom_range(0, 1 << (OFFSET_BITS - 1));
      end else begin
        y   = $urandom_range(9996, 9999);
        off = $urandom_range(0, (1 << (OFFSET_BITS - 1)) - 1);
      end
      return pack_word(good_date(y), off);
    end else if (pick < 80) begin
      case ($urandom_range(0, 8))
        0:       y = 0;
        1:       y = 4;
        2:       y = 100;
        3:       y = 400;
        4:       y = 1900;
        5:       y = 2000;
        6:       y = 2100;
        7:       y = 1996;
        default: y = 1999;
      endcase
      m = $urandom_range(2, 3);
      d = (m == 2) ? $urandom_range(27, 29) : 1;
      off = $urandom_range(0, 1) ? $urandom_range(0, 6) - 3 : $urandom_range(0, 800) - 400;
      return pack_word(y * 10000 + m * 100 + d, off);
    end else if (pick < 90) begin
      y = $urandom_range(0, 9999);
      m = $urandom_range(1, 12);
      case ($urandom_range(0, 3))
        0: return pack_word(y * 10000 + ($urandom_range(0, 1) ? 0 : $urandom_range(13, 99)) * 100
                            + $urandom_range(1, 28), off);
        1: return pack_word(y * 10000 + m * 100, off);
        2: return pack_word(y * 10000 + m * 100 + $urandom_range(month_end(m, y) + 1, 99), off);
        default: return pack_word($urandom_range(10000, 13421) * 10000 + good_date(0), off);
      endcase
    end else begin
      rd = DW'($urandom);
      return pack_word(int'(rd), off);
    end
  endfunction

  // One word per handshake; idles between bursts of random length.
  task automatic offer(logic [InW-1:0] w);
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    do @(posedge clk); while (!s_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 10);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer(pack_word(20240115, 10));
    offer(pack_word(20240131, 1));
    offer(pack_word(20231231, 1));
    offer(pack_word(20240101, -1));
    offer(pack_word(20240228, 1));
    offer(pack_word(20230228, 1));
    offer(pack_word(19000228, 1));
    offer(pack_word(20000228, 1));
    offer(pack_word(229, 0));
    offer(pack_word(101, -1));
    offer(pack_word(99991231, 1));
    offer(pack_word(99991231, -32768));
    offer(pack_word(101, 32767));
    offer(pack_word(20240315, 32767));
    offer(pack_word(20240315, -32768));
    offer(pack_word(20230229, 0));
    offer(pack_word(20241301, 0));
    offer(pack_word(20240001, 0));
    offer(pack_word(20240100, 0));
    offer(pack_word(20240431, 0));
    offer(pack_word(100000101, 0));
    offer(pack_word((1 << DW) - 1, -1));
    offer(pack_word(0, 0));
    offer(pack_word(20241130, 1));
    offer(pack_word(20241201, -1));
    wait_idle();

    for (int i = 0; i < RAND_WORDS; i++) begin
      offer(rand_word());
      if (i % 350 == 349) wait_idle();
    end

    wait_idle();
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Output side: random stall modes, plus one long hold-off to back up the input.
  initial begin : sink
    int mode, span, taken;
    bit held;
    taken = 0;
    held  = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(50, 400);
      repeat (span) begin
        @(posedge clk);
        if (m_tvalid && m_tready) taken++;
        if (!held && taken >= 300) begin
          held = 1'b1;
          m_tready <= 1'b0;
          repeat (3000) @(posedge clk);
        end else begin
          case (mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 9) < 7);
            default: m_tready <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* files.f */
hdl/cdad_pkg.sv
hdl/cdad_seq.sv
hdl/cdad_datapath.sv
hdl/calendar_date_add_days_top.sv
hdl/cdad_checker.sv
verif/date_add_checker.sv
verif/tb.sv
